// ===== rtl/core/bc_pkg.sv =====
// ----------------------------------------------------------------------------
// bc_pkg
// Shared widths, state encoding and control bundles for the binomial
// coefficient block.
// ----------------------------------------------------------------------------
`default_nettype none

package bc_pkg;

    localparam int N_W    = 7;
    localparam int COEF_W = 61;
    localparam int PROD_W = COEF_W + N_W;
    localparam int CNT_W  = 7;

    localparam logic [N_W-1:0]   MAX_N    = N_W'(64);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic steps_done;
        logic div_last;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bc_datapath.sv =====
// ----------------------------------------------------------------------------
// bc_datapath
// Running coefficient, step multiplier and one-bit-per-cycle restoring
// divider; holds the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module bc_datapath
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bc_pkg::cmd_t                cmd,
    output bc_pkg::status_t                  sts,
    input  wire logic [bc_pkg::N_W-1:0]      total_count,
    input  wire logic [bc_pkg::N_W-1:0]      chosen_count,
    output logic      [bc_pkg::COEF_W-1:0]   coefficient,
    output logic                             range_error
);

    logic [bc_pkg::N_W-1:0]    n_reg, n_next;
    logic [bc_pkg::N_W-1:0]    k_reg, k_next;
    logic [bc_pkg::N_W-1:0]    i_reg, i_next;
    logic                      err_reg, err_next;
    logic [bc_pkg::COEF_W-1:0] coef_reg, coef_next;
    logic [bc_pkg::PROD_W-1:0] dq_reg, dq_next;
    logic [bc_pkg::N_W-1:0]    r_reg, r_next;
    logic [bc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [bc_pkg::COEF_W-1:0] coefficient_reg, coefficient_next;
    logic                      range_error_reg, range_error_next;

    logic [bc_pkg::N_W-1:0]    diff;
    logic [bc_pkg::N_W-1:0]    term;
    logic [bc_pkg::PROD_W-1:0] prod;
    logic [bc_pkg::N_W-1:0]    r_shift;
    logic                      qbit;
    logic [bc_pkg::PROD_W-1:0] dq_shift;

    assign diff     = total_count - chosen_count;
    assign term     = n_reg - k_reg + i_reg;
    assign prod     = {{bc_pkg::N_W{1'b0}}, coef_reg} * {{bc_pkg::COEF_W{1'b0}}, term};
    assign r_shift  = {r_reg[bc_pkg::N_W-2:0], dq_reg[bc_pkg::PROD_W-1]};
    assign qbit     = (r_shift >= i_reg);
    assign dq_shift = {dq_reg[bc_pkg::PROD_W-2:0], qbit};

    always_comb
    begin
        n_next           = n_reg;
        k_next           = k_reg;
        i_next           = i_reg;
        err_next         = err_reg;
        coef_next        = coef_reg;
        dq_next          = dq_reg;
        r_next           = r_reg;
        cnt_next         = cnt_reg;
        coefficient_next = coefficient_reg;
        range_error_next = range_error_reg;
        if (cmd.load)
        begin
            n_next    = total_count;
            k_next    = (chosen_count < diff) ? chosen_count : diff;
            err_next  = (total_count > bc_pkg::MAX_N) || (chosen_count > total_count);
            i_next    = bc_pkg::N_W'(1);
            coef_next = bc_pkg::COEF_W'(1);
        end
        if (cmd.mul)
        begin
            dq_next  = prod;
            r_next   = '0;
            cnt_next = '0;
        end
        if (cmd.div_step)
        begin
            dq_next  = dq_shift;
            r_next   = qbit ? (r_shift - i_reg) : r_shift;
            cnt_next = cnt_reg + bc_pkg::CNT_W'(1);
            if (sts.div_last)
            begin
                coef_next = dq_shift[bc_pkg::COEF_W-1:0];
                i_next    = i_reg + bc_pkg::N_W'(1);
            end
        end
        if (cmd.publish)
        begin
            coefficient_next = err_reg ? '0 : coef_reg;
            range_error_next = err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        k_reg           <= k_next;
        i_reg           <= i_next;
        err_reg         <= err_next;
        coef_reg        <= coef_next;
        dq_reg          <= dq_next;
        r_reg           <= r_next;
        coefficient_reg <= coefficient_next;
        range_error_reg <= range_error_next;
    end

    always_comb
    begin
        sts.err        = err_reg;
        sts.steps_done = (i_reg > k_reg);
        sts.div_last   = (cnt_reg == bc_pkg::DIV_LAST);
    end

    assign coefficient = coefficient_reg;
    assign range_error = range_error_reg;

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (r_shift - (qbit ? i_reg : '0)) < i_reg)
        else $error("bc_datapath: remainder not below divisor");

    // every step divides exactly
    a_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && sts.div_last) |=> (r_reg == '0))
        else $error("bc_datapath: inexact division step");

endmodule

`default_nettype wire

// ===== rtl/core/bc_controller.sv =====
// ----------------------------------------------------------------------------
// bc_controller
// Sequencer: load, multiply and divide per step, then hand the word to the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bc_controller
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    input  wire bc_pkg::status_t sts,
    output bc_pkg::cmd_t         cmd
);

    bc_pkg::state_t state_reg, state_next;
    logic           out_valid_reg, out_valid_next;
    logic           slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bc_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = bc_pkg::S_CHECK;
            end
            bc_pkg::S_CHECK:
            begin
                if (sts.err || sts.steps_done)
                    state_next = bc_pkg::S_DONE;
                else
                    state_next = bc_pkg::S_MUL;
            end
            bc_pkg::S_MUL:
            begin
                state_next = bc_pkg::S_DIV;
            end
            bc_pkg::S_DIV:
            begin
                if (sts.div_last)
                    state_next = bc_pkg::S_CHECK;
            end
            bc_pkg::S_DONE:
            begin
                if (slot_free)
                    state_next = bc_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            bc_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            bc_pkg::S_MUL:
            begin
                cmd.mul = 1'b1;
            end
            bc_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            bc_pkg::S_DONE:
            begin
                cmd.publish = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
        out_valid_next = cmd.publish || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a waiting word is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.publish)
        else $error("bc_controller: output word overwritten");

    // divide runs to its last bit before the next step
    a_div_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bc_pkg::S_DIV && !sts.div_last) |=> (state_reg == bc_pkg::S_DIV))
        else $error("bc_controller: divide cut short");

endmodule

`default_nettype wire

// ===== rtl/core/binomial_coefficient.sv =====
// ----------------------------------------------------------------------------
// binomial_coefficient
// Exact n choose m over the smaller side, k = min(m, n-m).
// k <= 32 for n up to 64. Each step is a multiply, a one-bit-per-cycle
// divide and a check; one word in flight at a time, the next accepted
// while the last result waits.
// Reset: asynchronous, active low; clears sequencer and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_coefficient
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [bc_pkg::N_W-1:0]        total_count,
    input  wire logic [bc_pkg::N_W-1:0]        chosen_count,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [bc_pkg::COEF_W-1:0]     coefficient,
    output logic                               range_error
);

    bc_pkg::cmd_t    cmd;
    bc_pkg::status_t sts;

    bc_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bc_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .total_count  (total_count),
        .chosen_count (chosen_count),
        .coefficient  (coefficient),
        .range_error  (range_error)
    );

endmodule

`default_nettype wire
